>>> src/dsrt_pkg.sv
package dsrt_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int ID_W        = 31;
    localparam int DAY_W       = 5;
    localparam int MON_W       = 4;
    localparam int YEAR_W      = 14;
    localparam int DATE_W      = YEAR_W + MON_W + DAY_W;
    localparam int SLOT_W      = 4;
    localparam int SLOT_N      = 16;
    localparam int OUT_SLOT_W  = 5;
    localparam int TOTAL_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE    = 2'd0,
        FSM_MATCH   = 2'd1,
        FSM_FIND    = 2'd2,
        FSM_RESOLVE = 2'd3
    } fsm_t;

    // date packed as year:month:day, day in the lowest bits
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DATE_W-1:0] date;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic load_new;
        logic from_left;
        logic from_right;
    } cell_ctl_t;

endpackage

>>> src/dsrt_cell.sv
module dsrt_cell (
    input  logic               aclk,
    input  dsrt_pkg::cell_ctl_t ctl,
    input  dsrt_pkg::entry_t   key,
    input  logic               valid,
    input  dsrt_pkg::entry_t   left_entry,
    input  dsrt_pkg::entry_t   right_entry,
    output dsrt_pkg::entry_t   entry,
    output logic               lt,
    output logic               hit
);

    dsrt_pkg::entry_t entry_reg, entry_next;
    logic             lt_reg, lt_next;
    logic             hit_reg, hit_next;

    always_comb begin
        lt_next    = lt_reg;
        hit_next   = hit_reg;
        entry_next = entry_reg;
        if (ctl.capture) begin
            lt_next  = valid && (entry_reg.date < key.date);
            hit_next = valid && (entry_reg.id == key.id);
        end
        if (ctl.load_new) begin
            entry_next = key;
        end else if (ctl.from_left) begin
            entry_next = left_entry;
        end else if (ctl.from_right) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        lt_reg    <= lt_next;
        hit_reg   <= hit_next;
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign hit   = hit_reg;

endmodule

>>> src/dsrt_locate.sv
module dsrt_locate #(
    parameter int CAPACITY = dsrt_pkg::CAPACITY_DEF,
    localparam int IDX_W   = $clog2(CAPACITY)
) (
    input  logic [CAPACITY-1:0] hit,
    input  logic [CAPACITY-1:0] lt,
    input  logic [CAPACITY-1:0] rd_sel,
    input  dsrt_pkg::op_t       op,
    output logic [CAPACITY-1:0] pick,
    output logic [CAPACITY-1:0] shift_mask,
    output logic [IDX_W-1:0]    pos
);

    localparam int LEVELS = $clog2(CAPACITY);

    logic [CAPACITY-1:0] pre [LEVELS+1];
    logic [CAPACITY-1:0] first_hit;
    logic [CAPACITY-1:0] ins_sel;

    // inclusive prefix OR of the hit flags, log-depth
    always_comb begin
        pre[0] = hit;
        for (int l = 0; l < LEVELS; l++) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (i >= (1 << l)) begin
                    pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
                end else begin
                    pre[l+1][i] = pre[l][i];
                end
            end
        end
    end

    assign first_hit  = hit & ~{pre[LEVELS][CAPACITY-2:0], 1'b0};
    assign shift_mask = pre[LEVELS];

    // the held dates are sorted, so the later-than flags form a prefix
    always_comb begin
        ins_sel[0] = !lt[0];
        for (int i = 1; i < CAPACITY; i++) begin
            ins_sel[i] = !lt[i] && lt[i-1];
        end
    end

    always_comb begin
        case (op)
            dsrt_pkg::OP_INSERT: pick = ins_sel;
            dsrt_pkg::OP_READ:   pick = rd_sel;
            default:             pick = first_hit;
        endcase
    end

    always_comb begin
        pos = '0;
        for (int b = 0; b < IDX_W; b++) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (((i >> b) & 1) == 1) begin
                    pos[b] = pos[b] | pick[i];
                end
            end
        end
    end

endmodule

>>> src/date_sorted_record_table_unit.sv
// A result reaches the output register through transfer, cell compare, locate and commit
// of the chain, held back only while the output register still holds an untaken result.
// A new item is accepted only in the idle state, after the previous one has committed.
// Reset: aresetn low at a clock edge clears the state machine, the record count and the
// output valid; record contents are left as they are and only positions below the count
// are ever read.
module date_sorted_record_table_unit #(
    parameter int CAPACITY = dsrt_pkg::CAPACITY_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // key_id[30:0], pub_day[35:31], pub_month[39:36], pub_year[53:40],
    // slot_index[57:54], zero[63:58]
    input  logic [dsrt_pkg::IN_TDATA_W-1:0]    s_tdata,
    // opcode[1:0]
    input  logic [dsrt_pkg::OP_W-1:0]          s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // found_id[30:0], found_day[35:31], found_month[39:36], found_year[53:40],
    // found_slot[58:54], entry_total[63:59]
    output logic [dsrt_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // status[1:0]
    output logic [dsrt_pkg::STATUS_W-1:0]      m_tuser
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    dsrt_pkg::fsm_t   state_reg, state_next;
    dsrt_pkg::op_t    op_reg, op_next;
    dsrt_pkg::entry_t key_reg, key_next;
    logic [dsrt_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CAPACITY-1:0] pick_reg, pick_next;
    logic [CAPACITY-1:0] mask_reg, mask_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic                                 m_tvalid_reg, m_tvalid_next;
    logic [dsrt_pkg::OUT_TDATA_W-1:0]     m_tdata_reg, m_tdata_next;
    logic [dsrt_pkg::STATUS_W-1:0]        m_tuser_reg, m_tuser_next;

    dsrt_pkg::entry_t    cell_entry [CAPACITY];
    dsrt_pkg::cell_ctl_t cell_ctl [CAPACITY];
    logic [CAPACITY-1:0] cell_lt, cell_hit, cell_valid, rd_sel;
    logic [CAPACITY-1:0] loc_pick, loc_mask;
    logic [IDX_W-1:0]    loc_pos;

    logic commit, full, found, ins_ok, del_ok;
    dsrt_pkg::entry_t hit_entry;
    dsrt_pkg::entry_t res_entry;
    dsrt_pkg::status_t res_status;
    logic [IDX_W-1:0] res_pos;
    logic [CNT_W-1:0] count_after;
    logic [IDX_W+dsrt_pkg::OUT_SLOT_W-1:0] pos_wide;
    logic [CNT_W+dsrt_pkg::TOTAL_W-1:0]    total_wide;

    // ---------------------------------------------------------------- cell chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        dsrt_pkg::entry_t left_e, right_e;
        if (i == 0) begin : g_first
            assign left_e = cell_entry[i];
        end else begin : g_mid
            assign left_e = cell_entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_e = cell_entry[i];
        end else begin : g_inner
            assign right_e = cell_entry[i+1];
        end
        dsrt_cell u_cell (
            .aclk        (aclk),
            .ctl         (cell_ctl[i]),
            .key         (key_reg),
            .valid       (cell_valid[i]),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .lt          (cell_lt[i]),
            .hit         (cell_hit[i])
        );
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_valid[i] = CNT_W'(i) < count_reg;
            rd_sel[i]     = cell_valid[i] && (i < dsrt_pkg::SLOT_N)
                            && (slot_reg == dsrt_pkg::SLOT_W'(i));
        end
    end

    dsrt_locate #(
        .CAPACITY (CAPACITY)
    ) u_locate (
        .hit        (cell_hit),
        .lt         (cell_lt),
        .rd_sel     (rd_sel),
        .op         (op_reg),
        .pick       (loc_pick),
        .shift_mask (loc_mask),
        .pos        (loc_pos)
    );

    // ---------------------------------------------------------------- commit logic
    assign commit = (state_reg == dsrt_pkg::FSM_RESOLVE) && (!m_tvalid_reg || m_tready);
    assign full   = count_reg == CNT_W'(CAPACITY);
    assign found  = |pick_reg;
    assign ins_ok = (op_reg == dsrt_pkg::OP_INSERT) && !full;
    assign del_ok = (op_reg == dsrt_pkg::OP_DELETE) && found;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_ctl[i].capture    = state_reg == dsrt_pkg::FSM_MATCH;
            cell_ctl[i].load_new   = commit && ins_ok && pick_reg[i];
            cell_ctl[i].from_left  = commit && ins_ok && !cell_lt[i] && !pick_reg[i];
            cell_ctl[i].from_right = commit && del_ok && mask_reg[i];
        end
    end

    always_comb begin
        hit_entry = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_entry = hit_entry | (pick_reg[i] ? cell_entry[i] : '0);
        end
    end

    always_comb begin
        res_status  = dsrt_pkg::ST_MISSING;
        res_entry   = '0;
        res_pos     = '0;
        count_after = count_reg;
        if (op_reg == dsrt_pkg::OP_INSERT) begin
            if (full) begin
                res_status = dsrt_pkg::ST_FULL;
            end else begin
                res_status  = dsrt_pkg::ST_DONE;
                res_entry   = key_reg;
                res_pos     = pos_reg;
                count_after = count_reg + CNT_W'(1);
            end
        end else if (found) begin
            res_status = dsrt_pkg::ST_DONE;
            res_entry  = hit_entry;
            res_pos    = pos_reg;
            if (op_reg == dsrt_pkg::OP_DELETE) begin
                count_after = count_reg - CNT_W'(1);
            end
        end
    end

    assign pos_wide   = {{dsrt_pkg::OUT_SLOT_W{1'b0}}, res_pos};
    assign total_wide = {{dsrt_pkg::TOTAL_W{1'b0}}, count_after};

    // ---------------------------------------------------------------- control
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        slot_next     = slot_reg;
        count_next    = count_reg;
        pick_next     = pick_reg;
        mask_next     = mask_reg;
        pos_next      = pos_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        s_tready      = state_reg == dsrt_pkg::FSM_IDLE;
        case (state_reg)
            dsrt_pkg::FSM_IDLE: begin
                if (s_tvalid) begin
                    op_next       = dsrt_pkg::op_t'(s_tuser);
                    key_next.id   = s_tdata[30:0];
                    key_next.date = s_tdata[53:31];
                    slot_next     = s_tdata[57:54];
                    state_next    = dsrt_pkg::FSM_MATCH;
                end
            end
            dsrt_pkg::FSM_MATCH: begin
                state_next = dsrt_pkg::FSM_FIND;
            end
            dsrt_pkg::FSM_FIND: begin
                pick_next  = loc_pick;
                mask_next  = loc_mask;
                pos_next   = loc_pos;
                state_next = dsrt_pkg::FSM_RESOLVE;
            end
            dsrt_pkg::FSM_RESOLVE: begin
                if (commit) begin
                    count_next    = count_after;
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status;
                    m_tdata_next  = {total_wide[dsrt_pkg::TOTAL_W-1:0],
                                     pos_wide[dsrt_pkg::OUT_SLOT_W-1:0],
                                     res_entry.date, res_entry.id};
                    state_next    = dsrt_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = dsrt_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dsrt_pkg::FSM_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        slot_reg    <= slot_next;
        pick_reg    <= pick_next;
        mask_reg    <= mask_next;
        pos_reg     <= pos_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------------------------------------------------------- checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("record count beyond capacity");

    a_pick_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dsrt_pkg::FSM_RESOLVE) |-> $onehot0(pick_reg))
        else $error("more than one cell selected");

    a_count_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != dsrt_pkg::FSM_RESOLVE) |=> $stable(count_reg))
        else $error("record count changed outside commit");

    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == dsrt_pkg::FSM_MATCH))
        else $error("transfer did not start the compare step");

endmodule
